// ----- design/cns_pkg.sv -----
package cns_pkg;

  // Result and register widths fixed by the block's interface
  localparam int SUM_BITS  = 19;
  localparam int SIZE_BITS = 11;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd4;

  // Configuration address map: byte address, word index in the upper bit
  localparam int ADDR_BITS = 3;
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // Result queue geometry: up to three results enter per cycle
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = 3;
  localparam int FIFO_CNT_BITS = 4;
  localparam int PUSH_MAX      = 3;
  localparam int PUSH_CNT_BITS = 2;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic                last;
  } result_t;

  // Position of a cell in the matrix, as the sum stage needs it
  typedef struct packed {
    logic up1;       // row above exists
    logic up2;       // two rows above exist
    logic left1;     // column to the left exists
    logic left2;     // two columns to the left exist
    logic right1;    // column to the right exists
    logic last_row;
    logic last_col;
  } pos_flags_t;

endpackage

// ----- design/cns_line_store.sv -----
module cns_line_store #(
  parameter int DEPTH     = 1024,
  parameter int CELL_BITS = 16,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        rd_addr_right,
  input  logic [CELL_BITS-1:0] newer_wr_data,
  input  logic                 older_we,
  input  logic [AW-1:0]        older_wr_addr,
  input  logic [CELL_BITS-1:0] older_wr_data,
  output logic [CELL_BITS-1:0] newer_cur_r,
  output logic [CELL_BITS-1:0] newer_right_r,
  output logic [CELL_BITS-1:0] older_cur_r
);

  logic [CELL_BITS-1:0] newer_mem [DEPTH];
  logic [CELL_BITS-1:0] older_mem [DEPTH];

  // Newer row: read the column and its right neighbor, then replace the column
  // with the arriving cell (read-first, so the old value comes back)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      newer_cur_r              <= newer_mem[rd_addr];
      newer_right_r            <= newer_mem[rd_addr_right];
      newer_mem[rd_addr]       <= newer_wr_data;
    end
  end

  // Older row: read on transfer, write back the retired newer value in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_cur_r <= older_mem[rd_addr];
    end
    if (older_we) begin
      older_mem[older_wr_addr] <= older_wr_data;
    end
  end

endmodule

// ----- design/cns_result_fifo.sv -----
module cns_result_fifo
  import cns_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [PUSH_CNT_BITS-1:0] push_cnt,
  input  result_t                  push_data [PUSH_MAX],
  output logic [FIFO_CNT_BITS-1:0] count,
  output logic                     out_valid,
  input  logic                     out_stall,
  output result_t                  out_data
);

  result_t                  fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] count_r, count_nxt;
  logic                     pop;

  assign pop       = (count_r != '0) && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];
  assign count     = count_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_BITS'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the packed results in order
  always_ff @(posedge clk) begin
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (PUSH_CNT_BITS'(i) < push_cnt) begin
        fifo_mem[wr_ptr_r + FIFO_PTR_BITS'(i)] <= push_data[i];
      end
    end
  end

endmodule

// ----- design/cross_neighbour_sum.sv -----
// Channel   Ports                                  Transfer when
// -------   -------------------------------------  -----------------------------
// input     in_valid, in_stall, in_cell_value      in_valid high, in_stall low
// result    out_valid, out_stall, out_cross_sum,   out_valid high, out_stall low
//           out_last_of_matrix
// config    psel, penable, pwrite, paddr, pwdata,  psel, penable, pwrite, pready
//           prdata, pready                         all high
//
// One cell per cycle while in_stall is low; its results are summed from registered reads, then queued.
// On the last row each cell after the first yields two results (three at the final cell)
// and the single result port drains one per cycle while out_stall is low, so in_stall
// rises while the queue fills. Sustained input rate is set by the queue drain on the last
// row and by out_stall. Reset clears counters and queue and sets size to 4; line stores
// hold no reset value. A matrix_size write restarts the matrix at row 0, column 0.
module cross_neighbour_sum
  import cns_pkg::*;
#(
  parameter int MAX_SIZE  = 1024,
  parameter int CELL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CELL_BITS-1:0] in_cell_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SUM_BITS-1:0]  out_cross_sum,
  output logic                        out_last_of_matrix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_BITS-1:0]        paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW   = $clog2(MAX_SIZE);
  localparam int SW   = (SIZE_BITS > AW + 1) ? SIZE_BITS : AW + 1;
  localparam int WIDE = (CELL_BITS + 3 > SUM_BITS) ? CELL_BITS + 3 : SUM_BITS;

  function automatic logic signed [WIDE-1:0] widen(input logic signed [CELL_BITS-1:0] x);
    return WIDE'(x);
  endfunction

  // ---------------- configuration ----------------
  logic [SIZE_BITS-1:0] size_r;
  logic                 cfg_wr;
  logic [SW-1:0]        size_ext;
  logic [AW-1:0]        last_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[ADDR_BITS-1] == REG_MATRIX_SIZE);
  assign prdata = (paddr[ADDR_BITS-1] == REG_MATRIX_SIZE) ? 32'(size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      size_r <= pwdata[SIZE_BITS-1:0];
    end
  end

  // Clamp the size into 1..MAX_SIZE and keep the index of the last row/column
  assign size_ext = SW'(size_r);
  always_comb begin
    if (size_r == '0) begin
      last_idx = '0;
    end else if (size_ext > SW'(MAX_SIZE)) begin
      last_idx = AW'(MAX_SIZE - 1);
    end else begin
      last_idx = AW'(size_ext - SW'(1));
    end
  end

  // ---------------- position counters ----------------
  logic          in_xfer;
  logic [AW-1:0] row_r, row_nxt;
  logic [AW-1:0] col_r, col_nxt;
  pos_flags_t    pos;

  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_xfer) begin
      if (col_r == last_idx) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx) ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    pos.up1      = (row_r != '0);
    pos.up2      = (row_r != '0) && (row_r != AW'(1));
    pos.left1    = (col_r != '0);
    pos.left2    = (col_r != '0) && (col_r != AW'(1));
    pos.right1   = (col_r != last_idx);
    pos.last_row = (row_r == last_idx);
    pos.last_col = (col_r == last_idx);
  end

  // ---------------- line stores ----------------
  logic [AW-1:0]        rd_addr_right;
  logic [CELL_BITS-1:0] newer_cur, newer_right, older_cur;
  logic                 s2_valid_r;
  pos_flags_t           s2_pos_r;
  logic [CELL_BITS-1:0] s2_cell_r;
  logic [AW-1:0]        s2_col_r;

  assign rd_addr_right = pos.right1 ? col_r + AW'(1) : '0;

  cns_line_store #(
    .DEPTH     (MAX_SIZE),
    .CELL_BITS (CELL_BITS),
    .AW        (AW)
  ) u_line_store (
    .clk           (clk),
    .rd_en         (in_xfer),
    .rd_addr       (col_r),
    .rd_addr_right (rd_addr_right),
    .newer_wr_data (in_cell_value),
    .older_we      (s2_valid_r),
    .older_wr_addr (s2_col_r),
    .older_wr_data (newer_cur),
    .newer_cur_r   (newer_cur),
    .newer_right_r (newer_right),
    .older_cur_r   (older_cur)
  );

  // ---------------- sum stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s2_pos_r  <= pos;
      s2_cell_r <= in_cell_value;
      s2_col_r  <= col_r;
    end
  end

  // Previous column's center (older row, one to the left) and the two latest cells
  logic [CELL_BITS-1:0] prev_ctr_r;
  logic [CELL_BITS-1:0] recent0_r, recent1_r;

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      prev_ctr_r <= newer_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent0_r <= '0;
      recent1_r <= '0;
    end else if (s2_valid_r) begin
      recent1_r <= recent0_r;
      recent0_r <= s2_cell_r;
    end
  end

  logic signed [WIDE-1:0]  cur_w, nc_w, nr_w, oc_w, prev_w, rec0_w, rec1_w;
  logic signed [WIDE-1:0]  sum_above, sum_left, sum_own;
  logic                    v_above, v_left, v_own;
  result_t                 res_above, res_left, res_own;
  result_t                 push_data [PUSH_MAX];
  logic [PUSH_CNT_BITS-1:0] push_cnt;

  always_comb begin
    cur_w  = widen(s2_cell_r);
    nc_w   = widen(newer_cur);
    nr_w   = widen(newer_right);
    oc_w   = widen(older_cur);
    prev_w = widen(prev_ctr_r);
    rec0_w = widen(recent0_r);
    rec1_w = widen(recent1_r);

    // Cell one row above the arriving cell
    sum_above = nc_w + cur_w
              + (s2_pos_r.up2    ? oc_w   : '0)
              + (s2_pos_r.left1  ? prev_w : '0)
              + (s2_pos_r.right1 ? nr_w   : '0);
    // Last row: cell to the left of the arriving cell
    sum_left  = rec0_w + cur_w
              + (s2_pos_r.left2 ? rec1_w : '0)
              + (s2_pos_r.up1   ? prev_w : '0);
    // Final cell of the matrix
    sum_own   = cur_w
              + (s2_pos_r.left1 ? rec0_w : '0)
              + (s2_pos_r.up1   ? nc_w   : '0);

    v_above = s2_valid_r && s2_pos_r.up1;
    v_left  = s2_valid_r && s2_pos_r.last_row && s2_pos_r.left1;
    v_own   = s2_valid_r && s2_pos_r.last_row && s2_pos_r.last_col;

    res_above = '{sum: sum_above[SUM_BITS-1:0], last: 1'b0};
    res_left  = '{sum: sum_left[SUM_BITS-1:0],  last: 1'b0};
    res_own   = '{sum: sum_own[SUM_BITS-1:0],   last: 1'b1};

    // Pack present results in raster order
    push_data[0] = v_above ? res_above : (v_left ? res_left : res_own);
    push_data[1] = (v_above && v_left) ? res_left : res_own;
    push_data[2] = res_own;
    push_cnt     = PUSH_CNT_BITS'(v_above) + PUSH_CNT_BITS'(v_left)
                 + PUSH_CNT_BITS'(v_own);
  end

  // ---------------- result queue ----------------
  logic [FIFO_CNT_BITS-1:0] fifo_count;
  logic [FIFO_CNT_BITS:0]   fill_ahead;
  result_t                  out_res;

  cns_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .count     (fifo_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // Hold input unless the queue has room for the pending and the next cell's results
  assign fill_ahead = (FIFO_CNT_BITS + 1)'(fifo_count) + (FIFO_CNT_BITS + 1)'(push_cnt);
  assign in_stall   = fill_ahead > (FIFO_CNT_BITS + 1)'(FIFO_DEPTH - PUSH_MAX);

  assign out_cross_sum      = out_res.sum;
  assign out_last_of_matrix = out_res.last;

endmodule

// ----- tb/sv/cross_neighbour_sum_test.sv -----
`timescale 1ns / 100ps

module cross_neighbour_sum_test
  import cns_pkg::*;
;

  localparam int CELL_W        = 16;
  localparam int MAX_CELLS     = 1024;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCH_LIMIT   = 1000;
  localparam int RANDOM_CELLS  = 100;
  localparam logic [ADDR_BITS-1:0] SIZE_ADDR = {REG_MATRIX_SIZE, 2'b00};

  typedef enum logic {STEP_SIZE, STEP_CELL} step_kind_t;

  // One row of the directed plan: a size write or a cell, optionally with its sum typed in
  typedef struct packed {
    step_kind_t  kind;
    logic [31:0] value;
    logic        typed;
    result_t     exp;
  } plan_step_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [CELL_W-1:0] in_cell_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [SUM_BITS-1:0] out_cross_sum;
  logic                     out_last_of_matrix;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_BITS-1:0]     paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  // Stencil predictor state
  logic signed [CELL_W-1:0] older_row [MAX_CELLS];
  logic signed [CELL_W-1:0] newer_row [MAX_CELLS];
  logic signed [CELL_W-1:0] recent [2];
  logic [SIZE_BITS-1:0]     size_reg;
  int                       row_pos;
  int                       col_pos;
  result_t                  step_sums [3];
  int                       step_count;

  result_t    expected_sums [$];
  plan_step_t plan [$];

  int mismatch_count = 0;
  int cells_sent     = 0;
  int sums_checked   = 0;
  int size_writes    = 0;
  int quiet_cycles   = 0;
  bit idle_on        = 1'b0;
  bit hold_request   = 1'b0;

  cross_neighbour_sum u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_value      (in_cell_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cross_sum      (out_cross_sum),
    .out_last_of_matrix (out_last_of_matrix),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at sum %0d: %s got %0d expected %0d", sums_checked, what, got, want);
    mismatch_count++;
  endtask

  // Clamp the size register the way the block reads it
  function automatic int size_in_effect(input logic [SIZE_BITS-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_CELLS) return MAX_CELLS;
    return int'(size);
  endfunction

  // Sign-extend a cell to the sum width
  function automatic logic signed [SUM_BITS-1:0] to_sum(input logic signed [CELL_W-1:0] v);
    return SUM_BITS'(v);
  endfunction

  // Compute the sums released by one cell, then advance the line stores and position
  task automatic predict_cell(input logic signed [CELL_W-1:0] cell_val);
    int n, r, c;
    logic signed [SUM_BITS-1:0] s;
    n = size_in_effect(size_reg);
    r = row_pos;
    c = col_pos;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    step_count = 0;
    // sum for the cell one row above
    if (r >= 1) begin
      s = to_sum(newer_row[c]) + to_sum(cell_val);
      if (r >= 2) s = s + to_sum(older_row[c]);
      if (c >= 1) s = s + to_sum(older_row[c-1]);
      if (c + 1 < n) s = s + to_sum(newer_row[c+1]);
      step_sums[step_count].sum  = s;
      step_sums[step_count].last = 1'b0;
      step_count++;
    end
    // last row: sum for the cell to the left
    if (r == n - 1 && c >= 1) begin
      s = to_sum(recent[0]) + to_sum(cell_val);
      if (c >= 2) s = s + to_sum(recent[1]);
      if (r >= 1) s = s + to_sum(older_row[c-1]);
      step_sums[step_count].sum  = s;
      step_sums[step_count].last = 1'b0;
      step_count++;
    end
    // bottom-right cell closes the matrix with its own sum
    if (r == n - 1 && c == n - 1) begin
      s = to_sum(cell_val);
      if (c >= 1) s = s + to_sum(recent[0]);
      if (r >= 1) s = s + to_sum(newer_row[c]);
      step_sums[step_count].sum  = s;
      step_sums[step_count].last = 1'b1;
      step_count++;
    end
    older_row[c] = newer_row[c];
    newer_row[c] = cell_val;
    recent[1]    = recent[0];
    recent[0]    = cell_val;
    if (c + 1 < n) begin
      col_pos = c + 1;
      row_pos = r;
    end else begin
      col_pos = 0;
      row_pos = (r + 1 < n) ? r + 1 : 0;
    end
  endtask

  function automatic logic [CELL_W-1:0] pick_cell();
    logic [CELL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: begin
        v = CELL_W'($urandom_range(0, 15));
        v = v - 16'd8;
      end
      default: v = CELL_W'($urandom());
    endcase
    return v;
  endfunction

  // Offer one cell, hold it until the transfer, then record its sums
  task automatic send_cell(input logic [CELL_W-1:0] cell_val, input logic typed,
                           input result_t want);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_value <= cell_val;
    do @(posedge clk); while (in_stall);
    predict_cell(cell_val);
    if (typed) begin
      expected_sums.push_back(want);
    end else begin
      for (int k = 0; k < step_count; k++) expected_sums.push_back(step_sums[k]);
    end
    cells_sent++;
  endtask

  // Write matrix_size: setup cycle, then access cycle until pready
  task automatic write_size(input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SIZE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    size_reg = data[SIZE_BITS-1:0];
    row_pos  = 0;
    col_pos  = 0;
    size_writes++;
  endtask

  // Stop offering cells, wait for every sum, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] size_word, input int cells);
    drain_results();
    write_size(size_word);
    repeat (cells) send_cell(pick_cell(), 1'b0, '0);
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expected sum
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("result with none expected, sum", int'(out_cross_sum), 0);
      end else begin
        want = expected_sums.pop_front();
        if (out_cross_sum !== want.sum)
          report_mismatch("cross_sum", int'(out_cross_sum), int'($signed(want.sum)));
        if (out_last_of_matrix !== want.last)
          report_mismatch("last_of_matrix", int'(out_last_of_matrix), int'(want.last));
        sums_checked++;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main
    int random_cells, pick, n, area, cells;
    logic [SIZE_BITS-1:0] size;
    logic [31:0] word;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cell_value <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    // Predictor reset state
    for (int i = 0; i < MAX_CELLS; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    recent[0] = '0;
    recent[1] = '0;
    size_reg  = SIZE_RESET;
    row_pos   = 0;
    col_pos   = 0;

    // Directed plan: single cell, size zero, full-scale 3x3 pair with wrap, restart mid-matrix
    plan.push_back('{STEP_SIZE, 32'd1, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'h8000, 1'b1, {19'h78000, 1'b1}});
    plan.push_back('{STEP_SIZE, 32'd0, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'h7FFF, 1'b1, {19'h07FFF, 1'b1}});
    plan.push_back('{STEP_SIZE, 32'd3, 1'b0, '0});
    for (int i = 0; i < 18; i++)
      plan.push_back('{STEP_CELL, (i < 9) ? 32'h7FFF : 32'h8000, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'h0001, 1'b0, '0});
    plan.push_back('{STEP_SIZE, 32'd2, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'h7FFF, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'h8000, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'h0001, 1'b0, '0});
    plan.push_back('{STEP_CELL, 32'hFFFF, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan
    idle_on = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_SIZE) begin
        drain_results();
        write_size(plan[i].value);
      end else begin
        send_cell(plan[i].value[CELL_W-1:0], plan[i].typed, plan[i].exp);
      end
    end

    // Back-pressure: hold the result side long enough for the block to stall its input
    drain_results();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    run_phase(32'd6, 36);

    // Largest size through the clamp, a few cells along the first row
    idle_on = 1'b1;
    run_phase(32'd2047, 6);
    run_phase(32'd1024, 3);

    // Random phases, mostly whole matrices, some cut short by the next size write
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      idle_on = (random_cells < RANDOM_CELLS * 3 / 4) ? ($urandom_range(0, 3) != 0) : 1'b0;
      pick = $urandom_range(0, 19);
      if (pick == 0) size = '0;
      else if (pick == 1) size = SIZE_BITS'(1);
      else size = SIZE_BITS'($urandom_range(2, 8));
      n    = size_in_effect(size);
      area = n * n;
      if (area > 1 && $urandom_range(0, 3) == 0) cells = $urandom_range(1, area - 1);
      else cells = area * $urandom_range(1, 2);
      word = {21'd0, size};
      if ($urandom_range(0, 1) == 1) word = ($urandom() & ~32'h7FF) | word;
      run_phase(word, cells);
      random_cells += cells;
    end

    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d cells under %0d matrix size writes, %0d stencil sums compared",
             cells_sent, size_writes, sums_checked);
    $display("Sizes 0, 1, 1024 and 2047 were set; one long output hold-off filled the block");
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d sums still expected", mismatch_count, expected_sums.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
